### rtl/timw_pkg.sv
// Package for the invariant mass window block: widths, register codes,
// payload and control structs, the sequencer state type and helper functions.
// No dependencies.
package timw_pkg;

  // Field and state widths
  localparam int MOM_W   = 20;
  localparam int PSUM_W  = 23;
  localparam int ESUM_W  = 28;
  localparam int MASS_W  = 23;
  localparam int TMASS_W = 10;

  // Tracks accumulated per candidate; later tracks are dropped
  localparam int MAX_TRACKS = 8;
  localparam int TCNT_W     = $clog2(MAX_TRACKS + 1);

  // Datapath widths
  localparam int MUL_W  = 28;  // multiplier operand, widest is the energy sum
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 46;  // sum of three squared momentum sums
  localparam int RAD_W  = 56;  // root radicand
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int ITER_W = $clog2(ROOT_W);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MASS_W-1:0]  MASS_MAX       = '1;
  localparam logic [ESUM_W-1:0]  ESUM_MAX       = '1;
  localparam logic [TMASS_W-1:0] TRACK_MASS_RST = TMASS_W'(139);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 2;
  localparam logic [REG_W-1:0] REG_MASS_LOW   = 2'd0;
  localparam logic [REG_W-1:0] REG_MASS_HIGH  = 2'd1;
  localparam logic [REG_W-1:0] REG_FLAG_MODE  = 2'd2;
  localparam logic [REG_W-1:0] REG_TRACK_MASS = 2'd3;

  typedef struct packed {
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic signed [MOM_W-1:0] mom_z;
    logic                    last_track;
  } track_t;

  typedef struct packed {
    logic [MASS_W-1:0] value;
    logic [MASS_W-1:0] mass;
    logic              in_window;
  } result_t;

  typedef struct packed {
    logic [MASS_W-1:0]  mass_low;
    logic [MASS_W-1:0]  mass_high;
    logic               flag_mode;
    logic [TMASS_W-1:0] track_mass;
  } cfg_t;

  // Queued track with its front-end classification
  typedef struct packed {
    track_t trk;
    logic   accum;  // track is within the per-candidate limit
  } work_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_MASS_DIFF,
    ST_ROOT,
    ST_RESULT
  } back_state_t;

  // Magnitude of a track momentum component
  function automatic logic [MOM_W-1:0] abs_mom(input logic [MOM_W-1:0] v);
    logic [MOM_W:0] ext;
    logic [MOM_W:0] neg;
    ext = {v[MOM_W-1], v};
    neg = -ext;
    return v[MOM_W-1] ? neg[MOM_W-1:0] : v;
  endfunction

  // Magnitude of a momentum sum
  function automatic logic [PSUM_W-1:0] abs_psum(input logic [PSUM_W-1:0] v);
    logic [PSUM_W:0] ext;
    logic [PSUM_W:0] neg;
    ext = {v[PSUM_W-1], v};
    neg = -ext;
    return v[PSUM_W-1] ? neg[PSUM_W-1:0] : v;
  endfunction

  // Add a component to a momentum sum, clamping at the sum's limits
  function automatic logic [PSUM_W-1:0] sat_psum(input logic [PSUM_W-1:0] s,
                                                 input logic [MOM_W-1:0]  m);
    logic [PSUM_W:0] t;
    t = {s[PSUM_W-1], s} + {{(PSUM_W + 1 - MOM_W){m[MOM_W-1]}}, m};
    if (t[PSUM_W] != t[PSUM_W-1]) begin
      return t[PSUM_W] ? {1'b1, {(PSUM_W - 1){1'b0}}} : {1'b0, {(PSUM_W - 1){1'b1}}};
    end
    return t[PSUM_W-1:0];
  endfunction

endpackage

### rtl/timw_isqrt.sv
// Iterative integer square root, one result bit per cycle (restoring form).
// Depends on timw_pkg.
module timw_isqrt import timw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [ITER_W-1:0] iter;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;

  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down two radicand bits and test the next root bit
  assign rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = REM_W'({root, 2'b01});
  assign fits      = rem_shift >= trial;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_shift - trial : rem_shift;
      root <= {root[ROOT_W-2:0], fits};
    end else if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = root;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("root done while still iterating");

endmodule

### rtl/timw_front.sv
// Front end: accepts tracks, marks those within the per-candidate limit, and
// queues them for the back end. Depends on timw_pkg.
module timw_front import timw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   track_valid,
  output logic   track_ready,
  input  track_t track,
  output logic   work_valid,
  input  logic   work_ready,
  output work_t  work
);

  work_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic [TCNT_W-1:0]   track_cnt;

  logic push;
  logic pop;

  assign track_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign work_valid  = fill != '0;
  assign work        = slots[rd_ptr];
  assign push        = track_valid && track_ready;
  assign pop         = work_valid && work_ready;

  // Count tracks of the open candidate; a last track closes it
  always_ff @(posedge clk) begin
    if (rst) begin
      track_cnt <= '0;
    end else if (push) begin
      if (track.last_track) begin
        track_cnt <= '0;
      end else if (track_cnt < TCNT_W'(MAX_TRACKS)) begin
        track_cnt <= track_cnt + 1'b1;
      end
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].trk   <= track;
      slots[wr_ptr].accum <= track_cnt < TCNT_W'(MAX_TRACKS);
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    track_cnt <= TCNT_W'(MAX_TRACKS))
    else $error("track count beyond limit");

  a_fill_limit: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

### rtl/timw_back.sv
// Back end: squares and sums per track, track energy by root, and on the last
// track the candidate mass, window test and result register.
// Depends on timw_pkg and drives one timw_isqrt through its request struct.
module timw_back import timw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      work_valid,
  output logic      work_ready,
  input  work_t     work,
  output sqrt_req_t sqrt_req,
  input  sqrt_rsp_t sqrt_rsp,
  output logic      result_valid,
  input  logic      result_ready,
  output result_t   result
);

  back_state_t state;
  back_state_t state_next;

  logic [1:0]        step;
  logic              mass_phase;
  work_t             cur;
  logic [ESUM_W-1:0] energy_sum;
  logic [PSUM_W-1:0] px_sum;
  logic [PSUM_W-1:0] py_sum;
  logic [PSUM_W-1:0] pz_sum;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [PROD_W-1:0] e2;
  logic [MASS_W-1:0] mass_r;

  logic [MUL_W-1:0]  mul_a;
  logic [PROD_W-1:0] square;
  logic [ACC_W-1:0]  acc_sum;
  logic [RAD_W-1:0]  p_scaled;
  logic              e2_above;
  logic              first_term;
  logic              load_result;
  logic              win;
  logic [ESUM_W:0]   esum_add;
  logic [ROOT_W:0]   rounded;
  logic [ROOT_W-4:0] mass_full;

  // Select the value to square for this step
  always_comb begin
    unique case (step)
      2'd0: mul_a = mass_phase ? MUL_W'(energy_sum) : MUL_W'(abs_mom(cur.trk.mom_x));
      2'd1: mul_a = mass_phase ? MUL_W'(abs_psum(px_sum)) : MUL_W'(abs_mom(cur.trk.mom_y));
      2'd2: mul_a = mass_phase ? MUL_W'(abs_psum(py_sum)) : MUL_W'(abs_mom(cur.trk.mom_z));
      default: mul_a = mass_phase ? MUL_W'(abs_psum(pz_sum)) : MUL_W'(cfg.track_mass);
    endcase
  end

  assign square     = mul_a * mul_a;
  assign acc_sum    = acc + prod[ACC_W-1:0];
  assign p_scaled   = RAD_W'({acc, 8'h00});
  assign e2_above   = e2 > p_scaled;
  // The product from the previous step opens a fresh sum
  assign first_term = mass_phase ? (step == 2'd2) : (step == 2'd1);

  // Energy sum update, clamped at full scale
  assign esum_add  = {1'b0, energy_sum} + (ESUM_W + 1)'(sqrt_rsp.root);
  // Round the mass to MeV, half up
  assign rounded   = {1'b0, sqrt_rsp.root} + (ROOT_W + 1)'(8);
  assign mass_full = rounded[ROOT_W:4];

  assign win = (mass_r > cfg.mass_low) && (mass_r < cfg.mass_high);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (work_valid && (work.accum || work.trk.last_track)) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (step == 2'd3) state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = mass_phase ? ST_MASS_DIFF : ST_ROOT;
      end
      ST_MASS_DIFF: begin
        state_next = e2_above ? ST_ROOT : ST_RESULT;
      end
      ST_ROOT: begin
        if (sqrt_rsp.done) begin
          if (mass_phase) begin
            state_next = ST_RESULT;
          end else begin
            state_next = cur.trk.last_track ? ST_SQUARE : ST_IDLE;
          end
        end
      end
      ST_RESULT: begin
        if (load_result) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    work_ready        = state == ST_IDLE;
    load_result       = (state == ST_RESULT) && (!result_valid || result_ready);
    sqrt_req.start    = ((state == ST_SUM) && !mass_phase) ||
                        ((state == ST_MASS_DIFF) && e2_above);
    sqrt_req.radicand = mass_phase ? e2 - p_scaled : RAD_W'({acc_sum, 8'h00});
  end

  // Control state and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      mass_phase   <= 1'b0;
      energy_sum   <= '0;
      px_sum       <= '0;
      py_sum       <= '0;
      pz_sum       <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state == ST_SQUARE) ? step + 1'b1 : 2'd0;
      if (state == ST_IDLE && work_valid) mass_phase <= !work.accum;
      // Fold the finished track into the candidate sums
      if (state == ST_ROOT && sqrt_rsp.done && !mass_phase) begin
        mass_phase <= 1'b1;
        energy_sum <= esum_add[ESUM_W] ? ESUM_MAX : esum_add[ESUM_W-1:0];
        px_sum     <= sat_psum(px_sum, cur.trk.mom_x);
        py_sum     <= sat_psum(py_sum, cur.trk.mom_y);
        pz_sum     <= sat_psum(pz_sum, cur.trk.mom_z);
      end
      // Hand over the result and open a new candidate
      if (load_result) begin
        result_valid <= 1'b1;
        energy_sum   <= '0;
        px_sum       <= '0;
        py_sum       <= '0;
        pz_sum       <= '0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && work_valid) cur <= work;
    if (state == ST_SQUARE) begin
      prod <= square;
      if (step != 2'd0) begin
        if (mass_phase && step == 2'd1) begin
          e2 <= prod;
        end else begin
          acc <= first_term ? prod[ACC_W-1:0] : acc_sum;
        end
      end
    end
    if (state == ST_SUM) acc <= acc_sum;
    if (state == ST_MASS_DIFF && !e2_above) mass_r <= '0;
    if (state == ST_ROOT && sqrt_rsp.done && mass_phase) begin
      mass_r <= (mass_full > (ROOT_W - 3)'(MASS_MAX)) ? MASS_MAX : mass_full[MASS_W-1:0];
    end
    if (load_result) begin
      result.value     <= cfg.flag_mode ? MASS_W'(win) : mass_r;
      result.mass      <= mass_r;
      result.in_window <= win;
    end
  end

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    sqrt_req.start |-> !sqrt_rsp.busy)
    else $error("root started while busy");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_RESULT))
    else $error("result raised outside result state");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !sqrt_rsp.busy)
    else $error("root unit busy while sequencer idle");

endmodule

### rtl/track_invariant_mass_window.sv
// A track that is not last leaves the queue and is done once its energy root returns;
// a last track also goes through the mass stage and the window test before its result.
// The back end accepts no new track until it is through with the current one, and it
// waits on the 28-iteration square root unit for each root.
// Reset (rst, synchronous) clears sums, queue, result and sets register defaults.
// Top level: configuration registers, front end, back end and root unit.
// Depends on timw_pkg, timw_front, timw_back and timw_isqrt.
module track_invariant_mass_window import timw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               track_valid,
  output logic               track_ready,
  input  track_t             track,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  logic      work_valid;
  logic      work_ready;
  work_t     work;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;
  logic      cfg_write;
  logic [REG_W-1:0] reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[PADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass_low   <= '0;
      cfg.mass_high  <= MASS_MAX;
      cfg.flag_mode  <= 1'b0;
      cfg.track_mass <= TRACK_MASS_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_MASS_LOW:   cfg.mass_low   <= pwdata[MASS_W-1:0];
        REG_MASS_HIGH:  cfg.mass_high  <= pwdata[MASS_W-1:0];
        REG_FLAG_MODE:  cfg.flag_mode  <= pwdata[0];
        REG_TRACK_MASS: cfg.track_mass <= pwdata[TMASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_MASS_LOW:   prdata = PDATA_W'(cfg.mass_low);
      REG_MASS_HIGH:  prdata = PDATA_W'(cfg.mass_high);
      REG_FLAG_MODE:  prdata = PDATA_W'(cfg.flag_mode);
      REG_TRACK_MASS: prdata = PDATA_W'(cfg.track_mass);
      default:        prdata = '0;
    endcase
  end

  timw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .track_valid (track_valid),
    .track_ready (track_ready),
    .track       (track),
    .work_valid  (work_valid),
    .work_ready  (work_ready),
    .work        (work)
  );

  timw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .work_valid   (work_valid),
    .work_ready   (work_ready),
    .work         (work),
    .sqrt_req     (sqrt_req),
    .sqrt_rsp     (sqrt_rsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  timw_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

endmodule
